>>> hdl/permutation_unrank_macros.svh
// Assertion helpers used by the RTL file permutation_unrank.sv.
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRM_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRM_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/prm_pkg.sv
`default_nettype none

package prm_pkg;

  localparam int COUNT_W = 5;
  localparam int RANK_W  = 62;
  localparam int VALUE_W = 5;

  typedef logic [2:0] pc_t;

  localparam pc_t STEP_WAIT = 3'd0;
  localparam pc_t STEP_FACT = 3'd1;
  localparam pc_t STEP_DIV  = 3'd2;
  localparam pc_t STEP_EMIT = 3'd3;
  localparam pc_t STEP_ERR  = 3'd4;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_INPUT,
    COND_GE,
    COND_SLOT
  } cond_t;

  typedef struct packed {
    logic  load;
    logic  fact_load;
    logic  sub;
    logic  emit_val;
    logic  emit_err;
    cond_t cond;
    pc_t   target_a;
    pc_t   target_b;
  } ctl_t;

  function automatic logic [RANK_W-1:0] fact(input logic [COUNT_W-1:0] n);
    logic [RANK_W-1:0] f;
    unique case (n)
      5'd0:    f = 62'd1;
      5'd1:    f = 62'd1;
      5'd2:    f = 62'd2;
      5'd3:    f = 62'd6;
      5'd4:    f = 62'd24;
      5'd5:    f = 62'd120;
      5'd6:    f = 62'd720;
      5'd7:    f = 62'd5040;
      5'd8:    f = 62'd40320;
      5'd9:    f = 62'd362880;
      5'd10:   f = 62'd3628800;
      5'd11:   f = 62'd39916800;
      5'd12:   f = 62'd479001600;
      5'd13:   f = 62'd6227020800;
      5'd14:   f = 62'd87178291200;
      5'd15:   f = 62'd1307674368000;
      5'd16:   f = 62'd20922789888000;
      5'd17:   f = 62'd355687428096000;
      5'd18:   f = 62'd6402373705728000;
      5'd19:   f = 62'd121645100408832000;
      5'd20:   f = 62'd2432902008176640000;
      default: f = '1;
    endcase
    return f;
  endfunction

  // Control store: one word per step.
  function automatic ctl_t ucode(input pc_t pc);
    ctl_t c;
    c = '0;
    c.cond = COND_NEXT;
    c.target_a = STEP_WAIT;
    c.target_b = STEP_WAIT;
    unique case (pc)
      STEP_WAIT: begin
        c.load = 1'b1;
        c.cond = COND_INPUT;
        c.target_a = STEP_FACT;
        c.target_b = STEP_ERR;
      end
      STEP_FACT: begin
        c.fact_load = 1'b1;
        c.cond = COND_NEXT;
        c.target_a = STEP_DIV;
      end
      STEP_DIV: begin
        c.sub = 1'b1;
        c.cond = COND_GE;
        c.target_a = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.emit_val = 1'b1;
        c.cond = COND_SLOT;
        c.target_a = STEP_FACT;
        c.target_b = STEP_WAIT;
      end
      STEP_ERR: begin
        c.emit_err = 1'b1;
        c.cond = COND_SLOT;
      end
      default: begin
        c.cond = COND_NEXT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/prm_in_if.sv
`default_nettype none

interface prm_in_if;
  logic                          valid;
  logic                          ready;
  logic [prm_pkg::COUNT_W-1:0]   count;
  logic [prm_pkg::RANK_W-1:0]    rank;

  modport source (output valid, output count, output rank, input ready);
  modport sink   (input valid, input count, input rank, output ready);
endinterface

`default_nettype wire

>>> hdl/prm_out_if.sv
`default_nettype none

interface prm_out_if;
  logic                          valid;
  logic                          ready;
  logic [prm_pkg::VALUE_W-1:0]   value;
  logic                          last;
  logic                          rank_error;

  modport source (output valid, output value, output last, output rank_error, input ready);
  modport sink   (input valid, input value, input last, input rank_error, output ready);
endinterface

`default_nettype wire

>>> hdl/permutation_unrank.sv
// Lexicographic permutation unranking. Each input word (count n, rank k) yields the
// n values of the k-th permutation of 1..n, one output word per value, last marked;
// a count of zero or above MAX_ELEMENTS, or a rank of n! or more, yields one word
// with value 0, last and rank_error set. A small control store steps a datapath
// that divides the remaining rank by a factorial through repeated
// subtraction, walking a pointer over the unused-value mask once per subtraction.
// An item is accepted in the wait step; per value, the factorial step loads the
// divisor, the divide step subtracts it while the rank is not below it, and the
// emit step sends the value; an error item goes to the error step. Output stalls
// hold the emit steps; the next word is accepted while the final result still waits.
`default_nettype none

`include "permutation_unrank_macros.svh"

module permutation_unrank #(
  parameter int MAX_ELEMENTS = 20
) (
  input  logic      clk,
  input  logic      rst,
  prm_in_if.sink    items,
  prm_out_if.source results
);

  localparam int PW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  prm_pkg::pc_t  pc;
  prm_pkg::pc_t  pc_next;
  prm_pkg::ctl_t ctl;

  logic [MAX_ELEMENTS-1:0]          mask;
  logic [prm_pkg::RANK_W-1:0]       rank_left;
  logic [prm_pkg::COUNT_W-1:0]      digits_left;
  logic [prm_pkg::RANK_W-1:0]       divisor;
  logic [PW-1:0]                    ptr;

  logic                             out_valid;
  logic [prm_pkg::VALUE_W-1:0]      out_value;
  logic                             out_last;
  logic                             out_err;

  logic                             accept;
  logic                             in_bad;
  logic [MAX_ELEMENTS-1:0]          init_mask;
  logic                             ge;
  logic                             final_digit;
  logic                             slot_free;
  logic [MAX_ELEMENTS-1:0]          above;
  logic [MAX_ELEMENTS-1:0]          pe_in;
  logic [PW-1:0]                    pe_out;

  assign ctl = prm_pkg::ucode(pc);

  assign items.ready = (ctl.cond == prm_pkg::COND_INPUT);
  assign accept      = items.valid && items.ready;

  assign in_bad = (items.count == '0) ||
                  (items.count > prm_pkg::COUNT_W'(MAX_ELEMENTS)) ||
                  (items.rank >= prm_pkg::fact(items.count));

  assign ge          = rank_left >= divisor;
  assign final_digit = digits_left == prm_pkg::COUNT_W'(1);
  assign slot_free   = !out_valid || results.ready;

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      init_mask[i] = prm_pkg::COUNT_W'(i) < items.count;
      above[i]     = PW'(i) > ptr;
    end
  end

  // Lowest unused value, or the next one above the pointer.
  assign pe_in = ctl.fact_load ? mask : (mask & above);

  always_comb begin
    pe_out = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      if (pe_in[i]) begin
        pe_out = PW'(i);
      end
    end
  end

  always_comb begin
    pc_next = pc;
    unique case (ctl.cond)
      prm_pkg::COND_NEXT: begin
        pc_next = ctl.target_a;
      end
      prm_pkg::COND_INPUT: begin
        if (items.valid) begin
          pc_next = in_bad ? ctl.target_b : ctl.target_a;
        end
      end
      prm_pkg::COND_GE: begin
        if (!ge) begin
          pc_next = ctl.target_a;
        end
      end
      prm_pkg::COND_SLOT: begin
        if (slot_free) begin
          pc_next = (ctl.emit_err || final_digit) ? ctl.target_b : ctl.target_a;
        end
      end
      default: begin
        pc_next = prm_pkg::STEP_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= prm_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.emit_val || ctl.emit_err) && slot_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && accept) begin
      mask        <= init_mask;
      rank_left   <= items.rank;
      digits_left <= items.count;
    end
    if (ctl.fact_load) begin
      divisor <= prm_pkg::fact(digits_left - prm_pkg::COUNT_W'(1));
      ptr     <= pe_out;
    end
    if (ctl.sub && ge) begin
      rank_left <= rank_left - divisor;
      ptr       <= pe_out;
    end
    if (ctl.emit_val && slot_free) begin
      mask[ptr]   <= 1'b0;
      digits_left <= digits_left - prm_pkg::COUNT_W'(1);
      out_value   <= prm_pkg::VALUE_W'(ptr) + prm_pkg::VALUE_W'(1);
      out_last    <= final_digit;
      out_err     <= 1'b0;
    end
    if (ctl.emit_err && slot_free) begin
      out_value <= '0;
      out_last  <= 1'b1;
      out_err   <= 1'b1;
    end
  end

  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.last       = out_last;
  assign results.rank_error = out_err;

  `PRM_ASSERT_IMPL(a_emit_unused, clk, rst, ctl.emit_val && slot_free, mask[ptr], "value emitted twice")
  `PRM_ASSERT_NEXT(a_div_shrinks, clk, rst, ctl.sub && ge, rank_left < $past(rank_left), "rank did not shrink")
  `PRM_ASSERT_NEXT(a_err_word, clk, rst, ctl.emit_err && slot_free, results.valid && results.last && results.rank_error && (results.value == '0), "bad error word")
  `PRM_ASSERT_IMPL(a_digits_range, clk, rst, ctl.emit_val, (digits_left != '0) && (digits_left <= prm_pkg::COUNT_W'(MAX_ELEMENTS)), "digit count out of range")

endmodule

`default_nettype wire

>>> tb/permutation_unrank_tb.sv
`timescale 1ns / 100ps

module permutation_unrank_tb;

  localparam int MAX_N = 20;
  localparam int NUM_DIRECTED = 23;
  localparam int RANDOM_PER_PHASE = 50;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [prm_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        rank_error;
  } perm_word_t;

  typedef struct packed {
    logic [prm_pkg::COUNT_W-1:0] count;
    logic [prm_pkg::RANK_W-1:0]  rank;
    logic                        typed;
    perm_word_t                  word;
  } stim_row_t;

  logic clk;
  logic rst;

  prm_in_if  in_ch ();
  prm_out_if out_ch ();

  permutation_unrank #(
    .MAX_ELEMENTS(MAX_N)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .items(in_ch),
    .results(out_ch)
  );

  perm_word_t pending_words[$];
  stim_row_t  directed [NUM_DIRECTED];
  int         mismatches;
  int         src_idle_pct;
  int         snk_stall_pct;

  function automatic void expect_word(input perm_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic logic [63:0] factorial(input int m);
    logic [63:0] f;
    f = 64'd1;
    for (int i = 2; i <= m; i++) begin
      f = f * i;
    end
    return f;
  endfunction

  function automatic void unrank_expect(input logic [prm_pkg::COUNT_W-1:0] n,
                                        input logic [prm_pkg::RANK_W-1:0] k);
    logic [MAX_N-1:0] free_set;
    logic [63:0]      left;
    logic [63:0]      f;
    logic [63:0]      q;
    logic [63:0]      seen;
    perm_word_t       w;
    if (n == 0 || n > MAX_N || {2'b00, k} >= factorial(n)) begin
      w.value = '0;
      w.last = 1'b1;
      w.rank_error = 1'b1;
      expect_word(w);
      return;
    end
    free_set = '0;
    for (int b = 0; b < n; b++) begin
      free_set[b] = 1'b1;
    end
    left = {2'b00, k};
    for (int pos = n - 1; pos >= 0; pos--) begin
      f = factorial(pos);
      q = left / f;
      left = left % f;
      w.value = '0;
      seen = '0;
      for (int b = 0; b < MAX_N; b++) begin
        if (free_set[b] && w.value == 0) begin
          if (seen == q) begin
            w.value = prm_pkg::VALUE_W'(b + 1);
            free_set[b] = 1'b0;
          end else begin
            seen++;
          end
        end
      end
      w.last = (pos == 0);
      w.rank_error = 1'b0;
      expect_word(w);
    end
  endfunction

  task automatic send_word(input logic [prm_pkg::COUNT_W-1:0] c,
                           input logic [prm_pkg::RANK_W-1:0] r,
                           input logic typed, input perm_word_t word);
    logic fire;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.count <= c;
    in_ch.rank <= r;
    do begin
      @(negedge clk);
      fire = in_ch.ready;
      @(posedge clk);
    end while (!fire);
    if (typed) begin
      expect_word(word);
    end else begin
      unrank_expect(c, r);
    end
  endtask

  task automatic send_random_word();
    logic [63:0]                 r64;
    logic [63:0]                 span;
    logic [prm_pkg::COUNT_W-1:0] n;
    logic [prm_pkg::RANK_W-1:0]  k;
    int                          sel;
    r64 = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 8) begin
      case ($urandom_range(2))
        0: begin
          n = '0;
          k = r64[prm_pkg::RANK_W-1:0];
        end
        1: begin
          n = prm_pkg::COUNT_W'($urandom_range(MAX_N + 1, 31));
          k = r64[prm_pkg::RANK_W-1:0];
        end
        default: begin
          n = prm_pkg::COUNT_W'($urandom_range(1, MAX_N));
          span = (64'd1 << prm_pkg::RANK_W) - factorial(n);
          k = prm_pkg::RANK_W'(factorial(n) + r64 % span);
        end
      endcase
    end else begin
      n = (sel < 60) ? prm_pkg::COUNT_W'($urandom_range(1, 8))
                     : prm_pkg::COUNT_W'($urandom_range(9, MAX_N));
      k = prm_pkg::RANK_W'(r64 % factorial(n));
    end
    send_word(n, k, 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !rst && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(negedge clk) begin
    perm_word_t got;
    perm_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.value = out_ch.value;
      got.last = out_ch.last;
      got.rank_error = out_ch.rank_error;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word value=%0d last=%0b rank_error=%0b",
                 $time, got.value, got.last, got.rank_error);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          mismatches++;
        end
        if (got.rank_error !== want.rank_error) begin
          $display("%0t: rank_error expected %0b actual %0b",
                   $time, want.rank_error, got.rank_error);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("permutation_unrank regression: fail");
    $finish;
  end

  initial begin : stimulus
    int pct_src [4];
    int pct_snk [4];
    mismatches = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    pct_src = '{0, 88, 0, 26};
    pct_snk = '{0, 0, 88, 26};
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.count <= '0;
    in_ch.rank <= '0;
    directed = '{
      '{5'd1,  62'd0,                         1'b1, '{5'd1, 1'b1, 1'b0}},
      '{5'd1,  62'd1,                         1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd0,  62'd0,                         1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd0,  {prm_pkg::RANK_W{1'b1}},       1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd21, 62'd0,                         1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd31, {prm_pkg::RANK_W{1'b1}},       1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd2,  62'd0,                         1'b0, '0},
      '{5'd2,  62'd1,                         1'b0, '0},
      '{5'd2,  62'd2,                         1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd3,  62'd3,                         1'b0, '0},
      '{5'd3,  62'd5,                         1'b0, '0},
      '{5'd3,  62'd6,                         1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd4,  62'd23,                        1'b0, '0},
      '{5'd10, 62'd3628799,                   1'b0, '0},
      '{5'd10, 62'd3628800,                   1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd12, 62'd271828182,                 1'b0, '0},
      '{5'd17, 62'd355687428095999,           1'b0, '0},
      '{5'd18, 62'd6402373705728000,          1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd19, 62'd121645100408831999,        1'b0, '0},
      '{5'd20, 62'd0,                         1'b0, '0},
      '{5'd20, 62'd2432902008176639999,       1'b0, '0},
      '{5'd20, 62'd2432902008176640000,       1'b1, '{5'd0, 1'b1, 1'b1}},
      '{5'd20, {prm_pkg::RANK_W{1'b1}},       1'b1, '{5'd0, 1'b1, 1'b1}}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(directed[i].count, directed[i].rank, directed[i].typed,
                directed[i].word);
    end
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = pct_src[ph];
      snk_stall_pct = pct_snk[ph];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_random_word();
      end
    end
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("permutation_unrank regression: pass");
    end else begin
      $display("permutation_unrank regression: fail");
    end
    $finish;
  end

endmodule
